[hw/rtl/assert_macros.svh]
// Assertion macros used by the top level of the modular exponentiation unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define MEXP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define MEXP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/mexp_pkg.sv]
// Package with shared constants and controller/datapath interface types.
`default_nettype none

package mexp_pkg;

  localparam int unsigned WidthDef = 16;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [CfgIdxW-1:0] CFG_EXPONENT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MODULUS  = 2'd1;

  typedef enum logic [1:0] {
    OP_REDUCE,
    OP_SQUARE,
    OP_MULT
  } op_sel_e;

  typedef struct packed {
    logic    load;
    logic    start;
    op_sel_e op;
    logic    shift_exp;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic exp_msb;
    logic exp_zero;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/mexp_datapath.sv]
// Datapath with the bit-serial modular multiplier, operand registers and output register.
`default_nettype none

module mexp_datapath #(
  parameter int unsigned WIDTH = mexp_pkg::WidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mexp_pkg::cmd_t    cmd_i,
  output mexp_pkg::sts_t    sts_o,
  input  logic [WIDTH-1:0]  msg_i,
  input  logic [WIDTH-1:0]  exponent_i,
  input  logic [WIDTH-1:0]  modulus_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [WIDTH-1:0]  out_data_o
);
  import mexp_pkg::*;

  localparam int unsigned CntW = $clog2(WIDTH);

  logic [WIDTH-1:0] base_q, acc_q, a_q, b_q, r_q, e_q, out_q;
  logic [WIDTH-1:0] r_d, addend, one_mod, a_sel, b_sel;
  logic [WIDTH:0]   sum;
  logic [CntW-1:0]  cnt_q;
  op_sel_e          op_q;
  logic             busy_q, phase_q, done_q, out_valid_q, last;

  // One modulo the modulus; a zero modulus means plain wraparound.
  assign one_mod = (modulus_i == WIDTH'(1)) ? '0 : WIDTH'(1);

  // Even phase doubles the partial result, odd phase adds the multiplicand on a set bit.
  always_comb begin
    addend = phase_q ? (b_q[WIDTH-1] ? a_q : '0) : r_q;
    sum    = {1'b0, r_q} + {1'b0, addend};
    if (modulus_i == '0) begin
      r_d = sum[WIDTH-1:0];
    end else if (sum >= {1'b0, modulus_i}) begin
      r_d = WIDTH'(sum - {1'b0, modulus_i});
    end else begin
      r_d = sum[WIDTH-1:0];
    end
  end

  always_comb begin
    case (cmd_i.op)
      OP_REDUCE: begin
        a_sel = one_mod;
        b_sel = base_q;
      end
      OP_MULT: begin
        a_sel = base_q;
        b_sel = acc_q;
      end
      default: begin
        a_sel = acc_q;
        b_sel = acc_q;
      end
    endcase
  end

  assign last = busy_q && phase_q && (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      base_q <= msg_i;
      acc_q  <= one_mod;
      e_q    <= exponent_i;
    end
    if (cmd_i.shift_exp) begin
      e_q <= {e_q[WIDTH-2:0], 1'b0};
    end
    if (cmd_i.start) begin
      a_q  <= a_sel;
      b_q  <= b_sel;
      r_q  <= '0;
      op_q <= cmd_i.op;
    end else if (busy_q) begin
      r_q <= r_d;
      if (phase_q) begin
        b_q <= {b_q[WIDTH-2:0], 1'b0};
      end
    end
    if (last) begin
      case (op_q)
        OP_REDUCE: base_q <= r_d;
        default:   acc_q  <= r_d;
      endcase
    end
    if (cmd_i.load_out) begin
      out_q <= (exponent_i == '0) ? WIDTH'(1) : acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      phase_q     <= 1'b0;
      done_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      done_q <= last;
      if (cmd_i.start) begin
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
        cnt_q   <= CntW'(WIDTH - 1);
      end else if (busy_q) begin
        phase_q <= ~phase_q;
        if (phase_q) begin
          if (cnt_q == '0) begin
            busy_q <= 1'b0;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.mul_done = done_q;
  assign sts_o.exp_msb  = e_q[WIDTH-1];
  assign sts_o.exp_zero = (exponent_i == '0);
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[hw/rtl/mexp_ctrl.sv]
// Controller state machine that sequences square-and-multiply over the exponent bits.
`default_nettype none

module mexp_ctrl #(
  parameter int unsigned WIDTH = mexp_pkg::WidthDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output mexp_pkg::cmd_t cmd_o,
  input  mexp_pkg::sts_t sts_i
);
  import mexp_pkg::*;

  localparam int unsigned CntW = $clog2(WIDTH);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RED,
    ST_RED_WAIT,
    ST_SQR,
    ST_SQR_WAIT,
    ST_MUL,
    ST_MUL_WAIT,
    ST_NEXT,
    ST_FINISH
  } state_e;

  state_e          state_q;
  logic [CntW-1:0] cnt_q;
  logic            accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = OP_SQUARE;
    cmd_o.load      = accept;
    cmd_o.shift_exp = (state_q == ST_NEXT);
    cmd_o.load_out  = (state_q == ST_FINISH) && sts_i.out_free;
    case (state_q)
      ST_RED: begin
        cmd_o.start = 1'b1;
        cmd_o.op    = OP_REDUCE;
      end
      ST_SQR: begin
        cmd_o.start = 1'b1;
        cmd_o.op    = OP_SQUARE;
      end
      ST_MUL: begin
        cmd_o.start = 1'b1;
        cmd_o.op    = OP_MULT;
      end
      default: begin
        cmd_o.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cnt_q   <= CntW'(WIDTH - 1);
            state_q <= sts_i.exp_zero ? ST_FINISH : ST_RED;
          end
        end
        ST_RED:      state_q <= ST_RED_WAIT;
        ST_RED_WAIT: if (sts_i.mul_done) state_q <= ST_SQR;
        ST_SQR:      state_q <= ST_SQR_WAIT;
        ST_SQR_WAIT: begin
          if (sts_i.mul_done) begin
            state_q <= sts_i.exp_msb ? ST_MUL : ST_NEXT;
          end
        end
        ST_MUL:      state_q <= ST_MUL_WAIT;
        ST_MUL_WAIT: if (sts_i.mul_done) state_q <= ST_NEXT;
        ST_NEXT: begin
          if (cnt_q == '0) begin
            state_q <= ST_FINISH;
          end else begin
            cnt_q   <= cnt_q - 1'b1;
            state_q <= ST_SQR;
          end
        end
        ST_FINISH:   if (sts_i.out_free) state_q <= ST_IDLE;
        default:     state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/modular_exponentiation_unit.sv]
// Top level of the modular exponentiation unit with key registers and stream ports.
//
// Channel   Direction  Payload
// s_axis    in         tdata: message
// m_axis    out        tdata: result
// cfg       in         index 0 exponent, index 1 modulus
//
// One message is processed at a time by a bit-serial modular multiplier. An item
// costs one reduction of the message plus, for each exponent bit, one squaring, a
// step to the next bit and one extra product per set bit. An exponent of zero
// skips the products and gives the result 1.
// Reset sets exponent and modulus to 1; a finished result waits in the output
// register, and the next message is taken while it waits.
`default_nettype none

`include "assert_macros.svh"

module modular_exponentiation_unit #(
  parameter int unsigned WIDTH = mexp_pkg::WidthDef
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((WIDTH+7)/8)*8-1:0]             s_axis_tdata,  // message
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [((WIDTH+7)/8)*8-1:0]             m_axis_tdata,  // result
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [mexp_pkg::CfgIdxW-1:0]           cfg_index_i,
  input  logic [WIDTH-1:0]                       cfg_data_i
);
  import mexp_pkg::*;

  localparam int unsigned DataW = ((WIDTH + 7) / 8) * 8;

  logic [WIDTH-1:0] exponent_q, modulus_q, result;
  cmd_t             cmd;
  sts_t             sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exponent_q <= WIDTH'(1);
      modulus_q  <= WIDTH'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_EXPONENT: exponent_q <= cfg_data_i;
        CFG_MODULUS:  modulus_q  <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  mexp_ctrl #(
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  mexp_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .msg_i       (s_axis_tdata[WIDTH-1:0]),
    .exponent_i  (exponent_q),
    .modulus_i   (modulus_q),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (result)
  );

  assign m_axis_tdata = DataW'(result);

  `MEXP_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `MEXP_ASSERT_SAME(a_exp_zero, m_axis_tvalid && (exponent_q == '0), result == WIDTH'(1))
  `MEXP_ASSERT_SAME(a_mod_one,
                    m_axis_tvalid && (exponent_q != '0) && (modulus_q == WIDTH'(1)),
                    result == '0)
  `MEXP_ASSERT_SAME(a_reduced,
                    m_axis_tvalid && (exponent_q != '0) && (modulus_q != '0),
                    result < modulus_q)

endmodule

`default_nettype wire
